>>> rtl/dqc_pkg.sv
`default_nettype none

package dqc_pkg;

   // command codes carried in the request
   localparam logic [1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [1:0] CMD_READ_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ_TICK  = 2'd2;
   localparam logic [1:0] CMD_READ_TICK2 = 2'd3;

   // register indexes on the csr port
   localparam logic CSR_SETTLE_COUNT  = 1'b0;
   localparam logic CSR_BUTTON_ENABLE = 1'b1;

   localparam int COUNT_W = 8;
   localparam int STEP_W  = 16;

   localparam logic [COUNT_W-1:0] SETTLE_COUNT_RESET  = 8'd4;
   localparam logic               BUTTON_ENABLE_RESET = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic       pin_a;
      logic       pin_b;
      logic       pin_button;
   } req_type;

   typedef struct packed {
      logic signed [STEP_W-1:0] delta;
      logic signed [STEP_W-1:0] position;
      logic                     button_pressed;
      logic [1:0]               phase;
   } rsp_type;

   // the four transitions that count down: 0->2, 2->3, 3->1, 1->0
   function automatic logic is_down(input logic [1:0] old_ph, input logic [1:0] new_ph);
      logic res;
      res = ((old_ph == 2'd0) && (new_ph == 2'd2)) ||
            ((old_ph == 2'd2) && (new_ph == 2'd3)) ||
            ((old_ph == 2'd3) && (new_ph == 2'd1)) ||
            ((old_ph == 2'd1) && (new_ph == 2'd0));
      return res;
   endfunction

   // signed halving, truncating toward zero
   function automatic logic [STEP_W-1:0] half_trunc(input logic [STEP_W-1:0] v);
      logic [STEP_W-1:0] biased;
      biased = v + {{(STEP_W-1){1'b0}}, v[STEP_W-1]};
      return {biased[STEP_W-1], biased[STEP_W-1:1]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/dqc_debounce.sv
`default_nettype none

module dqc_debounce #(
   parameter int WIDTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic [WIDTH-1:0]            value,
   input  wire logic [dqc_pkg::COUNT_W-1:0] reload,
   output logic                             stable
);
   import dqc_pkg::*;

   logic [WIDTH-1:0]   candidate_ff, candidate_in;
   logic [COUNT_W-1:0] countdown_ff, countdown_in;

   always_comb begin
      candidate_in = candidate_ff;
      countdown_in = countdown_ff;
      if (candidate_ff != value) begin
         candidate_in = value;
         countdown_in = reload;
      end else if (countdown_ff != '0) begin
         countdown_in = countdown_ff - 1'b1;
      end
   end

   // stable once the updated countdown is at zero
   assign stable = (countdown_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= '0;
         countdown_ff <= '0;
      end else if (enable) begin
         candidate_ff <= candidate_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/debounced_quadrature_counter.sv
// a request transfer is captured in the input register, and its response in the response register
// throughput: one request per cycle; a full response register under stall holds the request side
// the whole item is worked combinationally between the input and response registers
// reset (synchronous, active high) clears phase, debouncers, step count and snapshots
// reset sets the settle count to 4 and button_enable to 1
`default_nettype none

module debounced_quadrature_counter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire dqc_pkg::req_type            req_payload,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output dqc_pkg::rsp_type                 rsp_payload,
   // register write port
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [dqc_pkg::COUNT_W-1:0] csr_wdata
);
   import dqc_pkg::*;

   // configuration registers
   logic [COUNT_W-1:0] settle_count_ff;
   logic               button_enable_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // counter state
   logic [1:0]        accepted_phase_ff, accepted_phase_in;
   logic              button_state_ff, button_state_in;
   logic [STEP_W-1:0] step_count_ff, step_count_in;
   logic [STEP_W-1:0] step_snap_ff, step_snap_in;
   logic [STEP_W-1:0] tick_snap_ff, tick_snap_in;
   logic [STEP_W-1:0] tick2_snap_ff, tick2_snap_in;

   logic              advance;
   logic              sample_en;
   logic              button_en;
   logic [1:0]        pin_phase;
   logic              pin_button;
   logic              phase_stable;
   logic              button_stable;
   logic [STEP_W-1:0] tick_val;
   logic [STEP_W-1:0] tick2_val;
   logic [STEP_W-1:0] delta_val;

   // ---------------------------------------------------------------
   // handshake: the held item moves on whenever the response register
   // is empty or being emptied this cycle
   // ---------------------------------------------------------------
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // ---------------------------------------------------------------
   // debouncers, stepped only on sample ticks
   // ---------------------------------------------------------------
   assign sample_en  = advance && (in_ff.cmd == CMD_SAMPLE);
   assign button_en  = sample_en && button_enable_ff;
   // pins are active low, phase is {b, a}
   assign pin_phase  = {~in_ff.pin_b, ~in_ff.pin_a};
   assign pin_button = ~in_ff.pin_button;

   dqc_debounce #(
      .WIDTH(2)
   ) u_phase_db (
      .clock  (clock),
      .reset  (reset),
      .enable (sample_en),
      .value  (pin_phase),
      .reload (settle_count_ff),
      .stable (phase_stable)
   );

   dqc_debounce #(
      .WIDTH(1)
   ) u_button_db (
      .clock  (clock),
      .reset  (reset),
      .enable (button_en),
      .value  (pin_button),
      .reload (settle_count_ff),
      .stable (button_stable)
   );

   // ---------------------------------------------------------------
   // step counter and read deltas
   // ---------------------------------------------------------------
   // tick and tick2 are the step count halved and quartered toward zero
   assign tick_val  = half_trunc(step_count_ff);
   assign tick2_val = half_trunc(tick_val);

   always_comb begin
      accepted_phase_in = accepted_phase_ff;
      step_count_in     = step_count_ff;
      button_state_in   = button_state_ff;
      step_snap_in      = step_snap_ff;
      tick_snap_in      = tick_snap_ff;
      tick2_snap_in     = tick2_snap_ff;
      delta_val         = '0;

      if (advance) begin
         case (in_ff.cmd)
            CMD_SAMPLE: begin
               // a settled phase that differs from the last one moves the count
               if (phase_stable && (pin_phase != accepted_phase_ff)) begin
                  if (is_down(accepted_phase_ff, pin_phase)) begin
                     step_count_in = step_count_ff - 1'b1;
                  end else begin
                     step_count_in = step_count_ff + 1'b1;
                  end
                  accepted_phase_in = pin_phase;
               end
               if (button_enable_ff && button_stable) begin
                  button_state_in = pin_button;
               end
            end
            CMD_READ_STEP: begin
               delta_val    = step_count_ff - step_snap_ff;
               step_snap_in = step_count_ff;
            end
            CMD_READ_TICK: begin
               delta_val    = tick_val - tick_snap_ff;
               tick_snap_in = tick_val;
            end
            default: begin
               delta_val     = tick2_val - tick2_snap_ff;
               tick2_snap_in = tick2_val;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.delta          = delta_val;
      rsp_in.position       = step_count_in;
      rsp_in.button_pressed = button_state_in;
      rsp_in.phase          = accepted_phase_in;
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_count_ff  <= SETTLE_COUNT_RESET;
         button_enable_ff <= BUTTON_ENABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETTLE_COUNT:  settle_count_ff  <= csr_wdata;
            CSR_BUTTON_ENABLE: button_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         accepted_phase_ff <= '0;
         button_state_ff   <= 1'b0;
         step_count_ff     <= '0;
         step_snap_ff      <= '0;
         tick_snap_ff      <= '0;
         tick2_snap_ff     <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         accepted_phase_ff <= accepted_phase_in;
         button_state_ff   <= button_state_in;
         step_count_ff     <= step_count_in;
         step_snap_ff      <= step_snap_in;
         tick_snap_ff      <= tick_snap_in;
         tick2_snap_ff     <= tick2_snap_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // a read leaves the count and phase alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.cmd != CMD_SAMPLE)) |=>
         ($stable(step_count_ff) && $stable(accepted_phase_ff)))
      else $error("read command changed count or phase");

   // the count moves by at most one per item
   assert property (@(posedge clock) disable iff (reset)
      advance |=> ((step_count_ff == $past(step_count_ff)) ||
                   (step_count_ff == $past(step_count_ff) + 16'd1) ||
                   (step_count_ff == $past(step_count_ff) - 16'd1)))
      else $error("step count jumped by more than one");

   // a held response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("response register overwritten while stalled");

   // with the button disabled its state holds
   assert property (@(posedge clock) disable iff (reset)
      (sample_en && !button_enable_ff) |=> $stable(button_state_ff))
      else $error("button state changed while disabled");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import dqc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // kinds of line in the directed script
   typedef enum logic {ROW_XFER, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         csr_idx;
      logic [7:0]   csr_val;
      req_type      item;
      logic         typed;     // response typed in by hand rather than predicted
      rsp_type      want;
   } script_row_type;

   // clock, reset and every block input start known
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_we      = 1'b0;
   logic       csr_index   = 1'b0;
   logic [7:0] csr_wdata   = '0;

   always #6 clock = ~clock;

   debounced_quadrature_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // ---------------------------------------------------------------
   // encoder mirror: configuration and state as the block holds them
   // ---------------------------------------------------------------
   logic [7:0]  enc_settle = SETTLE_COUNT_RESET;
   logic        enc_btn_on = BUTTON_ENABLE_RESET;
   logic [1:0]  enc_phase = '0;
   logic [1:0]  enc_ph_cand = '0;
   logic [7:0]  enc_ph_wait = '0;
   logic        enc_btn_cand = 1'b0;
   logic [7:0]  enc_btn_wait = '0;
   logic        enc_btn = 1'b0;
   logic [15:0] enc_steps = '0;
   logic [15:0] enc_steps_seen = '0;
   logic [15:0] enc_tick_seen = '0;
   logic [15:0] enc_tick2_seen = '0;

   // responses owed by the block, oldest first
   rsp_type due_reports[$];

   int mismatches = 0;
   int n_checked  = 0;
   int n_sent     = 0;
   int n_up       = 0;
   int n_down     = 0;
   int n_reads    = 0;
   int n_settings = 0;
   int cycles     = 0;

   // sender burst shaping
   int burst_left = 0;
   bit gaps_on    = 1'b1;

   // receiver stall pattern
   int stall_left = 0;
   int stall_mode = 0;
   int stall_age  = 0;

   // next phase along the quadrature cycle; up is 0-1-3-2, down is 0-2-3-1
   function automatic logic [1:0] rotate(input logic [1:0] ph, input bit up);
      logic [1:0] nxt;
      case (ph)
         2'd0:    nxt = up ? 2'd1 : 2'd2;
         2'd1:    nxt = up ? 2'd3 : 2'd0;
         2'd3:    nxt = up ? 2'd2 : 2'd1;
         default: nxt = up ? 2'd0 : 2'd3;
      endcase
      return nxt;
   endfunction

   // debounce countdown: reload on a change, else run down to zero
   function automatic logic [7:0] countdown(input logic changed, input logic [7:0] cnt);
      if (changed) return enc_settle;
      return (cnt != 0) ? cnt - 8'd1 : 8'd0;
   endfunction

   // advance the mirror by one accepted request and give the response it owes
   function automatic rsp_type advance_encoder(input req_type r);
      logic [1:0]  ph_in;
      logic        b_in;
      int          signed_steps;
      logic [15:0] tick_now;
      rsp_type     o;
      o.delta = '0;
      signed_steps = $signed(enc_steps);
      case (r.cmd)
         CMD_SAMPLE: begin
            // pins are active low
            ph_in = {~r.pin_b, ~r.pin_a};
            enc_ph_wait = countdown(ph_in != enc_ph_cand, enc_ph_wait);
            enc_ph_cand = ph_in;
            if (enc_ph_wait == 0 && ph_in != enc_phase) begin
               // illegal two-bit jumps count up like any other non-down move
               if (ph_in == rotate(enc_phase, 1'b0)) begin
                  enc_steps = enc_steps - 16'd1;
                  n_down++;
               end else begin
                  enc_steps = enc_steps + 16'd1;
                  n_up++;
               end
               enc_phase = ph_in;
            end
            // a disabled button leaves its debouncer and state frozen
            if (enc_btn_on) begin
               b_in = ~r.pin_button;
               enc_btn_wait = countdown(b_in != enc_btn_cand, enc_btn_wait);
               enc_btn_cand = b_in;
               if (enc_btn_wait == 0) enc_btn = b_in;
            end
         end
         CMD_READ_STEP: begin
            o.delta = enc_steps - enc_steps_seen;
            enc_steps_seen = enc_steps;
            n_reads++;
         end
         CMD_READ_TICK: begin
            // halving truncates toward zero
            tick_now = 16'(signed_steps / 2);
            o.delta = tick_now - enc_tick_seen;
            enc_tick_seen = tick_now;
            n_reads++;
         end
         default: begin
            tick_now = 16'((signed_steps / 2) / 2);
            o.delta = tick_now - enc_tick2_seen;
            enc_tick2_seen = tick_now;
            n_reads++;
         end
      endcase
      o.position       = enc_steps;
      o.button_pressed = enc_btn;
      o.phase          = enc_phase;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // one request transfer; called right after a rising edge
   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      // bursts of random length, separated by random gaps
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (gaps_on) burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge
      predicted = advance_encoder(r);
      due_reports.push_back(typed ? want : predicted);
      n_sent++;
   endtask

   // hold off the sender until every owed response has come back
   task automatic wait_all_reported();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_reports.size() != 0) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_csr(input logic idx, input logic [7:0] val);
      wait_all_reported();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_SETTLE_COUNT) enc_settle = val;
      else enc_btn_on = val[0];
      n_settings++;
   endtask

   // script line builders
   function automatic script_row_type xfer_row(input logic [1:0] cmd, input logic a,
                                               input logic b, input logic btn);
      script_row_type row;
      row      = '0;
      row.kind = ROW_XFER;
      row.item = '{cmd: cmd, pin_a: a, pin_b: b, pin_button: btn};
      return row;
   endfunction

   function automatic script_row_type known_row(input logic [1:0] cmd, input logic a,
                                                input logic b, input logic btn,
                                                input logic [15:0] delta,
                                                input logic [15:0] pos,
                                                input logic pressed, input logic [1:0] ph);
      script_row_type row;
      row       = xfer_row(cmd, a, b, btn);
      row.typed = 1'b1;
      row.want  = '{delta: delta, position: pos, button_pressed: pressed, phase: ph};
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic idx, input logic [7:0] val);
      script_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // random stretch under one setting: mostly clean rotation held long enough
   // to settle, with bounces, reversals, illegal jumps, reads and raw noise
   task automatic run_phase(input int n_items, input logic [7:0] settle, input logic btn_on,
                            input bit bursty);
      logic [1:0] ph;
      logic [1:0] nxt;
      logic       btn;
      bit         up;
      int         kind;
      int         dwell;
      int         sent;
      req_type    r;
      write_csr(CSR_SETTLE_COUNT, settle);
      write_csr(CSR_BUTTON_ENABLE, {7'd0, btn_on});
      gaps_on = bursty;
      ph   = enc_phase;
      btn  = enc_btn;
      up   = $urandom_range(0, 1);
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            // raw noise on every field
            repeat ($urandom_range(1, 4)) begin
               r = req_type'(5'($urandom_range(0, 31)));
               send_item(r, 1'b0, '0);
               sent++;
            end
         end else begin
            if (kind == 2) up = ~up;
            nxt = (kind == 1) ? ph ^ 2'b11 : rotate(ph, up);
            if ($urandom_range(0, 4) == 0) btn = ~btn;
            dwell = settle + 1 + $urandom_range(0, 2);
            // bounce: a short hold that may let go before the count runs out
            if (kind == 3) dwell = $urandom_range(1, settle + 1);
            repeat (dwell) begin
               if ($urandom_range(0, 6) == 0) begin
                  r     = req_type'(5'($urandom_range(0, 31)));
                  r.cmd = 2'($urandom_range(CMD_READ_STEP, CMD_READ_TICK2));
                  send_item(r, 1'b0, '0);
                  sent++;
               end
               r = '{cmd: CMD_SAMPLE, pin_a: ~nxt[0], pin_b: ~nxt[1], pin_button: ~btn};
               send_item(r, 1'b0, '0);
               sent++;
            end
            ph = nxt;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // response side: stall pattern and in-order check
   // ---------------------------------------------------------------
   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      logic    stall_next;
      rsp_type exp_rsp;
      stall_next = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected response transfer, expected none, actual %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               exp_rsp = due_reports.pop_front();
               compare_field("delta", int'(exp_rsp.delta), int'(rsp_payload.delta));
               compare_field("position", int'(exp_rsp.position), int'(rsp_payload.position));
               compare_field("button_pressed", exp_rsp.button_pressed,
                             rsp_payload.button_pressed);
               compare_field("phase", exp_rsp.phase, rsp_payload.phase);
               n_checked++;
            end
         end
         // stall mode drifts: none, scattered, or long runs
         stall_age++;
         if (stall_age > 97) begin
            stall_age  = 0;
            stall_mode = $urandom_range(0, 2);
         end
         if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 3) == 0);
               default: begin
                  if ($urandom_range(0, 9) == 0) begin
                     stall_left = $urandom_range(1, 11);
                     stall_next = 1'b1;
                  end
               end
            endcase
         end
      end
      rsp_stall <= stall_next;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      script_row_type directed[$];

      // reset defaults: settle count 4, button tracked
      directed.push_back(known_row(CMD_READ_STEP, 1'b1, 1'b1, 1'b1,
                                   16'd0, 16'd0, 1'b0, 2'd0));
      directed.push_back(known_row(CMD_SAMPLE, 1'b1, 1'b1, 1'b1,
                                   16'd0, 16'd0, 1'b0, 2'd0));
      // reads ignore the pins
      directed.push_back(known_row(CMD_READ_TICK, 1'b0, 1'b0, 1'b0,
                                   16'd0, 16'd0, 1'b0, 2'd0));
      directed.push_back(known_row(CMD_READ_TICK2, 1'b1, 1'b1, 1'b1,
                                   16'd0, 16'd0, 1'b0, 2'd0));
      // A and button held active until they settle: phase 1, one step up, pressed
      repeat (5) directed.push_back(xfer_row(CMD_SAMPLE, 1'b0, 1'b1, 1'b0));
      // zero settle count: every sample stable at once
      directed.push_back(csr_row(CSR_SETTLE_COUNT, 8'd0));
      // the four down moves, walking below zero
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b1, 1'b1, 1'b0));
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b1, 1'b0, 1'b0));
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b0, 1'b0, 1'b1));
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b0, 1'b1, 1'b1));
      // reads at a negative odd count: halving truncates toward zero
      directed.push_back(xfer_row(CMD_READ_STEP, 1'b1, 1'b1, 1'b1));
      directed.push_back(xfer_row(CMD_READ_TICK, 1'b0, 1'b0, 1'b0));
      directed.push_back(xfer_row(CMD_READ_TICK2, 1'b1, 1'b0, 1'b1));
      // illegal jump 1 to 2 counts up
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b1, 1'b0, 1'b1));
      // button ignored while disabled
      directed.push_back(csr_row(CSR_BUTTON_ENABLE, 8'd0));
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b1, 1'b0, 1'b0));
      directed.push_back(xfer_row(CMD_READ_STEP, 1'b0, 1'b1, 1'b0));
      directed.push_back(csr_row(CSR_BUTTON_ENABLE, 8'd1));
      // illegal jump 2 to 1, button pressed again
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b0, 1'b1, 1'b0));
      directed.push_back(xfer_row(CMD_READ_TICK, 1'b1, 1'b1, 1'b1));
      // longest settle count: a change starts a long wait
      directed.push_back(csr_row(CSR_SETTLE_COUNT, 8'd255));
      directed.push_back(xfer_row(CMD_SAMPLE, 1'b1, 1'b1, 1'b1));
      directed.push_back(xfer_row(CMD_READ_TICK2, 1'b1, 1'b1, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR)
            write_csr(directed[i].csr_idx, directed[i].csr_val);
         else
            send_item(directed[i].item, directed[i].typed, directed[i].want);
      end

      // random stretches over several settings, extremes included
      run_phase(60, 8'd0, 1'b1, 1'b1);
      run_phase(60, 8'd2, 1'b0, 1'b0);
      run_phase(60, 8'd1, 1'b1, 1'b1);
      run_phase(340, 8'd255, 1'b1, 1'b1);
      run_phase(60, 8'($urandom_range(3, 12)), 1'b1, 1'b0);

      // drain, then give any stray response time to show up
      wait_all_reported();
      repeat (8) @(posedge clock);

      $display("covered %0d request transfers under %0d register writes", n_sent, n_settings);
      $display("%0d steps up, %0d down, %0d reads; %0d responses compared",
               n_up, n_down, n_reads, n_checked);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
